// ===== rtl/sil_pkg.sv =====
`default_nettype none

package sil_pkg;

	// one classified beat passed from the front to the back
	typedef struct packed {
		logic signed [31:0] value;
		logic               refused;
	} sil_item_t;

	// back-end sequencer states
	typedef enum logic {
		B_IDLE,
		B_EMIT
	} sil_back_state_t;

endpackage

`default_nettype wire

// ===== rtl/sil_front.sv =====
`default_nettype none

module sil_front
	import sil_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] new_value,
	output logic                    item_valid,
	input  wire logic               item_ready,
	output sil_item_t               item
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic          hold_valid_q;
	sil_item_t     hold_q;
	logic [CW-1:0] fill_q;
	logic          full;

	// track the fill level the back will see; every beat adds one until full
	assign full = (fill_q == CW'(CAPACITY));

	assign in_ready   = !hold_valid_q || item_ready;
	assign item_valid = hold_valid_q;
	assign item       = hold_q;

	// hold a classified beat until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			fill_q       <= '0;
		end else begin
			if (in_valid && in_ready) begin
				hold_valid_q <= 1'b1;
				if (!full) begin
					fill_q <= fill_q + CW'(1);
				end
			end else if (item_ready) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	// classify the beat: refuse when the list is already full
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hold_q.value   <= new_value;
			hold_q.refused <= full;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sil_queue.sv =====
`default_nettype none

module sil_queue
	import sil_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_valid,
	output logic           wr_ready,
	input  wire sil_item_t wr_item,
	output logic           rd_valid,
	input  wire logic      rd_ready,
	output sil_item_t      rd_item
);

	sil_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] used_q;
	logic       push;
	logic       pop;

	assign wr_ready = (used_q != 2'd2);
	assign rd_valid = (used_q != 2'd0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			used_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				used_q <= used_q + 2'd1;
			end else if (pop && !push) begin
				used_q <= used_q - 2'd1;
			end
		end
	end

	// store the incoming beat
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sil_back.sv =====
`default_nettype none

module sil_back
	import sil_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire sil_item_t          item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      entry_value,
	output logic        [3:0]       entry_position,
	output logic                    last_entry,
	output logic                    insert_refused
);

	localparam int CW = $clog2(CAPACITY + 1);

	sil_back_state_t    state_q;
	sil_back_state_t    state_d;
	logic signed [31:0] cell_q    [CAPACITY];
	logic signed [31:0] ins_d     [CAPACITY];
	logic signed [31:0] rot_d     [CAPACITY];
	logic [CAPACITY-1:0] le;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      emit_q;
	logic [CW-1:0]      last_idx;
	logic [CW+3:0]      emit_ext;
	logic               refused_q;
	logic               pop;
	logic               insert_en;
	logic               rotate_en;
	logic               is_last;

	assign last_idx = count_q - CW'(1);
	assign is_last  = (emit_q == last_idx);
	assign emit_ext = {4'b0000, emit_q};

	assign entry_value    = cell_q[0];
	assign entry_position = emit_ext[3:0];
	assign last_entry     = is_last;
	assign insert_refused = refused_q;

	// per-cell insert and rotate candidates
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign le[i] = (CW'(i) < count_q) && (cell_q[i] <= item.value);

		if (i == 0) begin : g_first
			assign ins_d[i] = le[i] ? cell_q[i] : item.value;
		end else begin : g_rest
			assign ins_d[i] = le[i] ? cell_q[i] : (le[i-1] ? item.value : cell_q[i-1]);
		end

		if (i < CAPACITY - 1) begin : g_inner
			assign rot_d[i] = (CW'(i) == last_idx) ? cell_q[0] :
				((CW'(i) < last_idx) ? cell_q[i+1] : cell_q[i]);
		end else begin : g_top
			assign rot_d[i] = (CW'(i) == last_idx) ? cell_q[0] : cell_q[i];
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		out_valid  = 1'b0;
		pop        = 1'b0;
		rotate_en  = 1'b0;
		case (state_q)
			B_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					pop     = 1'b1;
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					rotate_en = 1'b1;
					if (is_last) begin
						state_d = B_IDLE;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	assign insert_en = pop && !item.refused;

	// state, fill count and emission index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			count_q <= '0;
			emit_q  <= '0;
		end else begin
			state_q <= state_d;
			if (insert_en) begin
				count_q <= count_q + CW'(1);
			end
			if (pop) begin
				emit_q <= '0;
			end else if (rotate_en) begin
				emit_q <= emit_q + CW'(1);
			end
		end
	end

	// insert in one step; rotate the filled cells once per beat out
	always_ff @(posedge clk) begin
		if (pop) begin
			refused_q <= item.refused;
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (insert_en) begin
				cell_q[i] <= ins_d[i];
			end else if (rotate_en) begin
				cell_q[i] <= rot_d[i];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sorted_insert_list.sv =====
`default_nettype none

// Channel | Signals                                             | Direction
// input   | in_valid, in_ready, new_value                       | in
// output  | out_valid, out_ready, entry_value, entry_position,  | out
//         | last_entry, insert_refused                          |
//
// Each item is inserted in one step, then listed one stored entry per output beat
// (entry count, at most CAPACITY); listing runs by rotating the cell row.
// A two-beat queue plus a front holding register let input beats arrive while
// a listing is still going out; the input stalls only when both are occupied.
// Reset empties the list; cell contents are not cleared.
// An output stall holds the current beat and pauses the rotation.
module sorted_insert_list
	import sil_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] new_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      entry_value,
	output logic        [3:0]       entry_position,
	output logic                    last_entry,
	output logic                    insert_refused
);

	sil_item_t f_item;
	logic      f_valid;
	logic      f_ready;
	sil_item_t b_item;
	logic      b_valid;
	logic      b_ready;

	// accept and classify
	sil_front #(
		.CAPACITY(CAPACITY)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.new_value  (new_value),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	// decouple front and back
	sil_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_item  (f_item),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_item  (b_item)
	);

	// insert and list
	sil_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (b_valid),
		.item_ready     (b_ready),
		.item           (b_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.entry_value    (entry_value),
		.entry_position (entry_position),
		.last_entry     (last_entry),
		.insert_refused (insert_refused)
	);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int LIST_CAPACITY  = 16;
	localparam int IDLE_LIMIT     = 5000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int SETTLE_CYCLES  = 2 * (LIST_CAPACITY + 2);

	// one beat of a listing run
	typedef struct {
		logic signed [31:0] value;
		logic        [3:0]  position;
		logic               last;
		logic               refused;
	} listing_beat_t;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               in_valid       = 1'b0;
	logic               in_ready;
	logic signed [31:0] new_value      = '0;
	logic               out_valid;
	logic               out_ready      = 1'b0;
	logic signed [31:0] entry_value;
	logic        [3:0]  entry_position;
	logic               last_entry;
	logic               insert_refused;

	// predicted list contents and the listing beats still owed by the block
	logic signed [31:0] sorted_model[$];
	listing_beat_t      pending_listing[$];

	int send_idle_pct   = 17;
	int recv_idle_pct   = 59;
	bit holdoff_start   = 1'b0;
	int holdoff_left    = 0;
	int idle_cycles     = 0;
	int mismatch_count  = 0;
	int beats_checked   = 0;
	int values_inserted = 0;
	int values_refused  = 0;

	sorted_insert_list #(.CAPACITY(LIST_CAPACITY)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.new_value      (new_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.entry_value    (entry_value),
		.entry_position (entry_position),
		.last_entry     (last_entry),
		.insert_refused (insert_refused)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// insert after every entry <= v, or refuse when full; queue the whole listing
	function automatic void predict_listing(input logic signed [31:0] v);
		int pos;
		int i;
		bit refused;
		listing_beat_t beat;
		refused = (sorted_model.size() >= LIST_CAPACITY);
		if (refused) begin
			values_refused++;
		end else begin
			pos = 0;
			while (pos < sorted_model.size() && sorted_model[pos] <= v)
				pos++;
			sorted_model.insert(pos, v);
			values_inserted++;
		end
		for (i = 0; i < sorted_model.size(); i++) begin
			beat.value    = sorted_model[i];
			beat.position = i[3:0];
			beat.last     = (i == sorted_model.size() - 1);
			beat.refused  = refused;
			pending_listing.push_back(beat);
		end
	endfunction

	// offer one value, with an optional random gap first; hold until accepted
	task automatic send_value(input logic signed [31:0] v);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		new_value <= v;
		do @(posedge clk); while (!in_ready);
		predict_listing(v);
	endtask

	// drop valid and wait until every owed beat has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_listing.size() != 0);
	endtask

	function automatic logic signed [31:0] random_new_value();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $signed($urandom_range(0, 200)) - 100;
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	// fill the list: extremes, duplicates, front, middle and back insertion
	task automatic test_directed_fill();
		send_value(32'sd0);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(-32'sd1);
		send_value(32'sd1);
		send_value(32'sd0);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'sd100);
		send_value(-32'sd100);
		send_value(32'sd50);
		send_value(32'sd0);
		send_value(32'h5555_5555);
		send_value(32'hAAAA_AAAA);
		send_value(32'h7FFF_FFFE);
		send_value(32'h8000_0001);
	endtask

	// full list: values are dropped, unchanged listing still comes out
	task automatic test_full_refusal();
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'sd0);
	endtask

	task automatic test_random_values(input int count, input int s_pct, input int r_pct);
		int n;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (n = 0; n < count; n++)
			send_value(random_new_value());
	endtask

	// stall the output for a long stretch while values keep coming
	task automatic test_output_holdoff();
		int n;
		holdoff_start = 1'b1;
		for (n = 0; n < 12; n++)
			send_value(random_new_value());
	endtask

	// pause the input until the block is empty, then resume
	task automatic test_drain_pause();
		int n;
		for (n = 0; n < 4; n++)
			send_value(random_new_value());
		wait_drained();
		for (n = 0; n < 4; n++)
			send_value(random_new_value());
	endtask

	// drive output ready: random stalls, or a counted hold-off when requested
	always @(posedge clk) begin
		if (holdoff_start) begin
			holdoff_left  = HOLDOFF_CYCLES;
			holdoff_start = 1'b0;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// compare each output beat with the oldest owed beat
	always @(posedge clk) begin : check_listing
		listing_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_checked++;
			if (pending_listing.size() == 0) begin
				report_mismatch("beat with nothing owed, entry_value", entry_value, 0);
			end else begin
				want = pending_listing.pop_front();
				if (entry_value !== want.value)
					report_mismatch("entry_value", entry_value, want.value);
				if (entry_position !== want.position)
					report_mismatch("entry_position", entry_position, want.position);
				if (last_entry !== want.last)
					report_mismatch("last_entry", last_entry, want.last);
				if (insert_refused !== want.refused)
					report_mismatch("insert_refused", insert_refused, want.refused);
			end
		end
	end

	// end the run when no beat moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_fill();
		test_full_refusal();
		test_random_values(90, 17, 59);
		test_random_values(90, 59, 17);
		test_random_values(60, 0, 0);
		test_output_holdoff();
		test_drain_pause();

		// let trailing beats out, then give the block time to misbehave
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d insertions and %0d refusals at capacity %0d,",
			values_inserted, values_refused, LIST_CAPACITY);
		$display("%0d listing beats checked under input and output stalls.", beats_checked);
		if (mismatch_count == 0 && pending_listing.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
